// File: src/mbrc_pkg.sv
// shared types, constants and the byte-wide crc update for the modbus rtu response checker
// no dependencies
package mbrc_pkg;

  localparam int unsigned MAX_REGISTERS = 125;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_REGISTERS = 2'd1;

  // frame status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_EXCEPTION      = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE     = 3'd2;
  localparam logic [2:0] ST_CRC_ERROR      = 3'd3;
  localparam logic [2:0] ST_COUNT_MISMATCH = 3'd4;
  localparam logic [2:0] ST_WRONG_SLAVE    = 3'd5;
  localparam logic [2:0] ST_WRONG_FUNCTION = 3'd6;

  // item kinds
  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  // header constants
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  FUNC_EXCEPTION  = 8'h84;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
  localparam logic [7:0]  EXCEPTION_LEN   = 8'd5;
  localparam logic [7:0]  FRAME_OVERHEAD  = 8'd5;
  localparam logic [7:0]  HEADER_LEN      = 8'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic [6:0]  index;
    logic [2:0]  status;
    logic [6:0]  count;
  } out_item_t;

  // crc-16/modbus, one byte, bit at a time (eight short steps)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/modbus_rtu_response_checker.sv
// top level of the modbus rtu read-input-registers response checker
// depends on mbrc_pkg for types, codes and the crc update
//
// usage:
//   input channel (in_valid / in_stall): one received byte per item, with frame_end set
//   when the line went quiet after that byte. each accepted byte updates the running crc
//   and header capture in the same cycle, so one byte per clock is taken unless stalled.
//   output channel (out_valid / out_stall): register words are sent tentatively as the
//   low byte of each register arrives; when the frame ends (expected length reached or
//   frame_end seen) a status item follows with is_last high. one byte can cause two
//   items (last register word and status), so results go through a 4-entry queue.
//   latency: an item shows on the output the cycle after its byte is accepted when the
//   queue is empty. throughput: one byte per cycle; in_stall rises only while fewer than
//   two queue slots are free, which is set by the output draining one item per cycle.
//   when the receiver stalls, the queue fills and then stalls the byte source; nothing
//   is dropped.
//   configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; index 0
//   is the slave address, index 1 the expected register count, other indexes ignored.
//   reset (rst, synchronous): slave address 1, expected registers 1, frame state cleared,
//   queue emptied.
module modbus_rtu_response_checker
  import mbrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // byte input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_end,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 item_kind,
  output logic [15:0]          register_value,
  output logic [6:0]           register_index,
  output logic [2:0]           frame_status,
  output logic [6:0]           register_count,
  output logic                 is_last,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // configuration registers
  logic [7:0] slave_address;
  logic [6:0] expected_registers;

  // frame state
  logic [7:0]  byte_position;
  logic [15:0] running_crc;
  logic [7:0]  address_byte;
  logic [7:0]  function_byte;
  logic [7:0]  count_byte;
  logic [7:0]  held_byte;

  // result queue
  out_item_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  fill;

  // per-byte logic
  logic        in_acc;
  logic        out_acc;
  logic [6:0]  e_used;
  logic [7:0]  two_e;
  logic [7:0]  frame_len;
  logic [7:0]  offset;
  logic [7:0]  received;
  logic [15:0] crc_next;
  logic [7:0]  address_next;
  logic [7:0]  function_next;
  logic [7:0]  count_next;
  logic [7:0]  held_next;
  logic        word_done;
  logic        frame_done;
  logic [2:0]  status_sel;
  out_item_t   reg_item;
  out_item_t   stat_item;
  out_item_t   first_item;
  logic [FIFO_CNT_W-1:0] push_n;
  logic [FIFO_CNT_W-1:0] pop_n;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // keep two slots free so a byte closing a register and the frame fits
  assign in_stall  = (fill > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (fill != '0);

  always_comb begin
    e_used = (expected_registers > 7'(MAX_REGISTERS)) ? 7'(MAX_REGISTERS) : expected_registers;
    two_e     = {e_used, 1'b0};
    frame_len = two_e + FRAME_OVERHEAD;
    crc_next  = crc_byte(running_crc, rx_byte);
    offset    = byte_position - HEADER_LEN;

    address_next  = address_byte;
    function_next = function_byte;
    count_next    = count_byte;
    held_next     = held_byte;
    word_done     = 1'b0;

    case (byte_position)
      8'd0: address_next  = rx_byte;
      8'd1: function_next = rx_byte;
      8'd2: count_next    = rx_byte;
      default: begin
        if (offset < two_e) begin
          // even offset is a high byte, odd offset completes the word
          if (!offset[0]) begin
            held_next = rx_byte;
          end else begin
            word_done = 1'b1;
          end
        end
      end
    endcase

    received   = (byte_position == 8'hFF) ? 8'hFF : byte_position + 8'd1;
    frame_done = (received >= frame_len) || frame_end;

    // status in priority order
    if (received == EXCEPTION_LEN && function_next == FUNC_EXCEPTION) begin
      status_sel = ST_EXCEPTION;
    end else if (received < frame_len) begin
      status_sel = ST_INCOMPLETE;
    end else if (crc_next != '0) begin
      status_sel = ST_CRC_ERROR;
    end else if (count_next != two_e) begin
      status_sel = ST_COUNT_MISMATCH;
    end else if (address_next != slave_address) begin
      status_sel = ST_WRONG_SLAVE;
    end else if (function_next != FUNC_READ_INPUT) begin
      status_sel = ST_WRONG_FUNCTION;
    end else begin
      status_sel = ST_OK;
    end

    reg_item.kind   = KIND_REGISTER;
    reg_item.value  = {held_byte, rx_byte};
    reg_item.index  = offset[7:1];
    reg_item.status = ST_OK;
    reg_item.count  = '0;

    stat_item.kind   = KIND_STATUS;
    stat_item.value  = '0;
    stat_item.index  = '0;
    stat_item.status = status_sel;
    stat_item.count  = (status_sel == ST_OK) ? e_used : 7'd0;

    first_item = word_done ? reg_item : stat_item;

    push_n = in_acc ? (FIFO_CNT_W'(word_done) + FIFO_CNT_W'(frame_done)) : '0;
    pop_n  = FIFO_CNT_W'(out_acc);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_acc && (word_done || frame_done)) begin
      fifo_mem[wr_ptr] <= first_item;
    end
    if (in_acc && word_done && frame_done) begin
      fifo_mem[wr_ptr + FIFO_PTR_W'(1)] <= stat_item;
    end
  end

  // control, configuration and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address      <= 8'd1;
      expected_registers <= 7'd1;
      byte_position      <= '0;
      running_crc        <= CRC_INIT;
      address_byte       <= '0;
      function_byte      <= '0;
      count_byte         <= '0;
      held_byte          <= '0;
      wr_ptr             <= '0;
      rd_ptr             <= '0;
      fill               <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLAVE_ADDRESS:      slave_address      <= cfg_data;
          REG_EXPECTED_REGISTERS: expected_registers <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        if (frame_done) begin
          // new frame starts with the next byte
          byte_position <= '0;
          running_crc   <= CRC_INIT;
          address_byte  <= '0;
          function_byte <= '0;
          count_byte    <= '0;
          held_byte     <= '0;
        end else begin
          byte_position <= received;
          running_crc   <= crc_next;
          address_byte  <= address_next;
          function_byte <= function_next;
          count_byte    <= count_next;
          held_byte     <= held_next;
        end
      end

      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop_n);
      fill   <= fill + push_n - pop_n;
    end
  end

  // output fields from the queue head
  assign item_kind      = fifo_mem[rd_ptr].kind;
  assign register_value = fifo_mem[rd_ptr].value;
  assign register_index = fifo_mem[rd_ptr].index;
  assign frame_status   = fifo_mem[rd_ptr].status;
  assign register_count = fifo_mem[rd_ptr].count;
  assign is_last        = fifo_mem[rd_ptr].kind;

  // queue never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // a byte that ends the frame restarts the byte count
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && frame_done |=> byte_position == '0 && running_crc == CRC_INIT)
    else $error("frame state not cleared after frame end");

  // a register word only completes past the header and one data byte
  a_word_position: assert property (@(posedge clk) disable iff (rst)
    in_acc && word_done |-> byte_position >= 8'd4)
    else $error("register word completed inside the header");

  // a fresh frame always starts from the crc seed
  a_crc_seed: assert property (@(posedge clk) disable iff (rst)
    byte_position == '0 |-> running_crc == CRC_INIT)
    else $error("crc not seeded at frame start");

endmodule

// File: sim/modbus_rtu_response_checker_tb.sv
// testbench for the modbus rtu read-input-registers response checker: directed frames, then
// random frames under three stall mixes, every result checked against a byte-level predictor
// depends on mbrc_pkg and modbus_rtu_response_checker
`timescale 1ns / 1ps

module modbus_rtu_response_checker_tb
  import mbrc_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;   // block answers the cycle after a byte
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned SEG_BYTES     = 14;
  localparam int unsigned MAX_SHOWN     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic [6:0]  index;
    logic [2:0]  status;
    logic [6:0]  count;
    logic        last;
  } frame_item_t;

  // directed table: plain bytes, the low / high byte of the crc so far, or a register write
  typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           data;
    logic                 fe;
    logic                 typed;     // status and count below replace the predicted ones
    logic [2:0]           t_status;
    logic [6:0]           t_count;
  } dir_row_t;

  localparam int DIR_ROWS = 32;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           rx_byte;
  logic                 frame_end;
  logic                 out_valid;
  logic                 out_stall;
  logic                 item_kind;
  logic [15:0]          register_value;
  logic [6:0]           register_index;
  logic [2:0]           frame_status;
  logic [6:0]           register_count;
  logic                 is_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  // predictor copy of the configuration and the frame state
  logic [7:0]  cfg_slave;
  logic [6:0]  cfg_regs;
  int unsigned pos_cnt;
  logic [15:0] crc_acc;
  logic [7:0]  hdr_addr;
  logic [7:0]  hdr_func;
  logic [7:0]  hdr_count;
  logic [7:0]  hi_byte;

  frame_item_t results_due[$];
  frame_item_t want;
  int          error_count;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CFG,  REG_EXPECTED_REGISTERS, 8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CFG,  REG_SLAVE_ADDRESS,      8'hFE,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CFG,  REG_UNUSED_2,           8'hFF,           1'b0, 1'b0, ST_OK, 7'd0},
    // exception reply, exactly five bytes
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'hFE,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      FUNC_EXCEPTION,  1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_LO, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_HI, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b1, ST_EXCEPTION, 7'd0},
    // good crc, other slave
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'h01,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      FUNC_READ_INPUT, 1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_LO, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_HI, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b1, ST_WRONG_SLAVE, 7'd0},
    // good crc, other function
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'hFE,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      FUNC_READ_HOLDING, 1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_LO, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_HI, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b1, ST_WRONG_FUNCTION, 7'd0},
    // good crc, byte count says two bytes of data
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'hFE,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      FUNC_READ_INPUT, 1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'h02,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_LO, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_HI, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b1, ST_COUNT_MISMATCH, 7'd0},
    // empty but valid reply, line goes quiet right on the last byte
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'hFE,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      FUNC_READ_INPUT, 1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_LO, REG_SLAVE_ADDRESS,    8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CRC_HI, REG_SLAVE_ADDRESS,    8'h00,           1'b1, 1'b1, ST_OK, 7'd0},
    '{ROW_CFG,  REG_UNUSED_3,           8'h00,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CFG,  REG_EXPECTED_REGISTERS, 8'h01,           1'b0, 1'b0, ST_OK, 7'd0},
    '{ROW_CFG,  REG_SLAVE_ADDRESS,      8'h01,           1'b0, 1'b0, ST_OK, 7'd0},
    // a single byte then silence
    '{ROW_BYTE, REG_SLAVE_ADDRESS,      8'hFF,           1'b1, 1'b1, ST_INCOMPLETE, 7'd0}
  };

  modbus_rtu_response_checker DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // crc-16/modbus over one byte, reflected, lsb first
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    return r;
  endfunction

  // register count in force, values above the maximum saturate
  function automatic int unsigned regs_in_use();
    return (cfg_regs > MAX_REGISTERS) ? MAX_REGISTERS : int'(cfg_regs);
  endfunction

  // advance the frame state by one accepted byte and queue the items it should cause
  task automatic follow_frame_byte(input logic [7:0] b, input logic fe, input logic typed,
                                   input logic [2:0] t_status, input logic [6:0] t_count);
    int unsigned e;
    int unsigned len;
    int unsigned got;
    logic [2:0]  st;
    e   = regs_in_use();
    len = 2 * e + 5;
    crc_acc = crc16_step(crc_acc, b);
    if (pos_cnt == 0) begin
      hdr_addr = b;
    end else if (pos_cnt == 1) begin
      hdr_func = b;
    end else if (pos_cnt == 2) begin
      hdr_count = b;
    end else if (pos_cnt - 3 < 2 * e) begin
      if (((pos_cnt - 3) & 1) == 0) begin
        hi_byte = b;
      end else begin
        results_due.push_back('{KIND_REGISTER, {hi_byte, b}, 7'((pos_cnt - 3) >> 1),
                                ST_OK, 7'd0, 1'b0});
      end
    end
    got = (pos_cnt >= 255) ? 255 : pos_cnt + 1;
    pos_cnt = got;
    if (got >= len || fe) begin
      // exception replies skip the crc check, the rest go in priority order
      if (got == EXCEPTION_LEN && hdr_func == FUNC_EXCEPTION) begin
        st = ST_EXCEPTION;
      end else if (got < len) begin
        st = ST_INCOMPLETE;
      end else if (crc_acc != 16'h0000) begin
        st = ST_CRC_ERROR;
      end else if (hdr_count != 2 * e) begin
        st = ST_COUNT_MISMATCH;
      end else if (hdr_addr != cfg_slave) begin
        st = ST_WRONG_SLAVE;
      end else if (hdr_func != FUNC_READ_INPUT) begin
        st = ST_WRONG_FUNCTION;
      end else begin
        st = ST_OK;
      end
      if (typed) begin
        results_due.push_back('{KIND_STATUS, 16'h0000, 7'd0, t_status, t_count, 1'b1});
      end else begin
        results_due.push_back('{KIND_STATUS, 16'h0000, 7'd0, st,
                                (st == ST_OK) ? 7'(e) : 7'd0, 1'b1});
      end
      pos_cnt   = 0;
      crc_acc   = CRC_INIT;
      hdr_addr  = 8'h00;
      hdr_func  = 8'h00;
      hdr_count = 8'h00;
      hi_byte   = 8'h00;
    end
  endtask

  // hand one byte to the block; entered and left just after a falling edge
  task automatic put_byte(input logic [7:0] b, input logic fe, input logic typed,
                          input logic [2:0] t_status, input logic [6:0] t_count);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    rx_byte   = b;
    frame_end = fe;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    follow_frame_byte(b, fe, typed, t_status, t_count);
    bytes_sent++;
    @(negedge clk);
  endtask

  // register writes only once every queued item is out and the pipeline has settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == REG_SLAVE_ADDRESS) begin
      cfg_slave = d;
    end else if (idx == REG_EXPECTED_REGISTERS) begin
      cfg_regs = d[6:0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one random frame: mostly well-formed replies with random data, some broken or cut
  // short, some exception replies and some line noise; full forces a clean reply
  task automatic send_frame(input int unsigned e, input bit full);
    logic [7:0]  fr[$];
    logic [15:0] c;
    int unsigned pick;
    int unsigned pos;
    int unsigned cut;
    logic        fe_last;
    bit          noisy;
    pick    = full ? 0 : $urandom_range(99);
    noisy   = 1'b0;
    fe_last = 1'b0;
    if (pick < 65) begin
      fr.push_back((full || $urandom_range(99) < 85) ? cfg_slave : 8'($urandom_range(255)));
      fr.push_back((full || $urandom_range(99) < 90) ? FUNC_READ_INPUT
                                                      : 8'($urandom_range(255)));
      fr.push_back((full || $urandom_range(99) < 90) ? 8'(2 * e) : 8'($urandom_range(255)));
      repeat (2 * e) fr.push_back(8'($urandom_range(255)));
      c = CRC_INIT;
      foreach (fr[i]) c = crc16_step(c, fr[i]);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      if (!full) begin
        // corrupt one bit somewhere, usually caught by the crc
        if ($urandom_range(99) < 10) begin
          pos = $urandom_range(fr.size() - 1);
          fr[pos] = fr[pos] ^ 8'(1 << $urandom_range(7));
        end
        fe_last = 1'($urandom_range(1));
        // long replies only go in cut short unless a full one is asked for
        if (e > 8 || $urandom_range(99) < 12) begin
          cut = $urandom_range(fr.size() - 1, 1);
          fr = fr[0:cut-1];
          fe_last = 1'b1;
        end
      end
    end else if (pick < 80) begin
      fr.push_back(($urandom_range(99) < 85) ? cfg_slave : 8'($urandom_range(255)));
      fr.push_back(FUNC_EXCEPTION);
      fr.push_back(8'($urandom_range(255)));
      c = CRC_INIT;
      foreach (fr[i]) c = crc16_step(c, fr[i]);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      fe_last = (e != 0) ? 1'b1 : 1'($urandom_range(1));
    end else begin
      repeat ($urandom_range(8, 1)) fr.push_back(8'($urandom_range(255)));
      noisy   = 1'b1;
      fe_last = 1'b1;
    end
    foreach (fr[i]) begin
      if (i == fr.size() - 1) begin
        put_byte(fr[i], fe_last, 1'b0, ST_OK, 7'd0);
      end else begin
        put_byte(fr[i], noisy && ($urandom_range(99) < 10), 1'b0, ST_OK, 7'd0);
      end
    end
  endtask

  // receiver side stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare every accepted item with the oldest one due
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        if (error_count < MAX_SHOWN) begin
          $display("unexpected item: kind %0d value %h index %0d status %0d count %0d last %0d",
                   item_kind, register_value, register_index, frame_status,
                   register_count, is_last);
        end
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (want.kind !== item_kind || want.value !== register_value ||
            want.index !== register_index || want.status !== frame_status ||
            want.count !== register_count || want.last !== is_last) begin
          if (error_count < MAX_SHOWN) begin
            $display("expected kind %0d value %h index %0d status %0d count %0d last %0d",
                     want.kind, want.value, want.index, want.status, want.count, want.last);
            $display("got      kind %0d value %h index %0d status %0d count %0d last %0d",
                     item_kind, register_value, register_index, frame_status,
                     register_count, is_last);
          end
          error_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    dir_row_t    row;
    logic [15:0] crc_hold;
    logic [7:0]  slave_val;
    logic [7:0]  regs_val;
    int unsigned e_used;
    int unsigned seg_start;
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = 8'h00;
    frame_end      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_SLAVE_ADDRESS;
    cfg_data       = 8'h00;
    error_count    = 0;
    bytes_sent     = 0;
    send_gap_pct   = 25;
    recv_stall_pct = 56;
    crc_hold       = CRC_INIT;
    // predictor starts from the reset state
    cfg_slave = 8'd1;
    cfg_regs  = 7'd1;
    pos_cnt   = 0;
    crc_acc   = CRC_INIT;
    hdr_addr  = 8'h00;
    hdr_func  = 8'h00;
    hdr_count = 8'h00;
    hi_byte   = 8'h00;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_CFG: begin
          write_reg(row.idx, row.data);
        end
        ROW_CRC_LO: begin
          crc_hold = crc_acc;
          put_byte(crc_hold[7:0], row.fe, row.typed, row.t_status, row.t_count);
        end
        ROW_CRC_HI: begin
          put_byte(crc_hold[15:8], row.fe, row.typed, row.t_status, row.t_count);
        end
        default: begin
          put_byte(row.data, row.fe, row.typed, row.t_status, row.t_count);
        end
      endcase
    end

    // random part: three stall mixes, four register settings each
    for (int m = 0; m < 3; m++) begin
      send_gap_pct   = (m == 0) ? 25 : (m == 1) ? 56 : 0;
      recv_stall_pct = (m == 0) ? 56 : (m == 1) ? 25 : 0;
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(9))
          0:       slave_val = 8'h00;
          1:       slave_val = 8'hFF;
          2:       slave_val = 8'h01;
          3:       slave_val = 8'hFE;
          default: slave_val = 8'($urandom_range(255));
        endcase
        // top bit of the count write is dropped by the 7-bit register
        regs_val = {1'($urandom_range(1)), 7'($urandom_range(4))};
        if (m == 0 && s == 3) regs_val = 8'hFF;   // saturates to the maximum
        if (m == 1 && s == 3) regs_val = 8'h7D;   // exactly the maximum
        // a partial frame may still be open here, so the new length applies mid-frame
        write_reg(REG_SLAVE_ADDRESS, slave_val);
        write_reg(REG_EXPECTED_REGISTERS, regs_val);
        if ($urandom_range(3) == 0) begin
          write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, 8'($urandom_range(255)));
        end
        e_used = regs_in_use();
        if (m == 0 && s == 3) begin
          send_frame(e_used, 1'b1);
        end else begin
          seg_start = bytes_sent;
          while (bytes_sent - seg_start < SEG_BYTES) send_frame(e_used, 1'b0);
        end
        // leave the next frame half received now and then
        if ($urandom_range(1)) begin
          for (int k = 0; k < int'($urandom_range(6, 1)); k++) begin
            case (k)
              0:       put_byte(cfg_slave, 1'b0, 1'b0, ST_OK, 7'd0);
              1:       put_byte(FUNC_READ_INPUT, 1'b0, 1'b0, ST_OK, 7'd0);
              2:       put_byte(8'(2 * e_used), 1'b0, 1'b0, ST_OK, 7'd0);
              default: put_byte(8'($urandom_range(255)), 1'b0, 1'b0, ST_OK, 7'd0);
            endcase
          end
        end
      end
    end

    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: modbus_rtu_response_checker.f
src/mbrc_pkg.sv
src/modbus_rtu_response_checker.sv
sim/modbus_rtu_response_checker_tb.sv
